### rtl/core/mf2d_pkg.sv
// Shared constants and types for the 2D median filter.
package mf2d_pkg;
  localparam int MaxWidth   = 1024;
  localparam int MaxRadius  = 3;
  localparam int HeightLim  = 4096;
  localparam int StoreRows  = 2 * MaxRadius + 2;
  localparam int WinSide    = 2 * MaxRadius + 1;
  localparam int WinMax     = WinSide * WinSide;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(HeightLim);
  localparam int SlotW      = $clog2(StoreRows);
  localparam int AddrW      = SlotW + ColW;
  localparam int CntW       = $clog2(WinMax + 1);

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef struct packed {
    logic [ColW:0] width;
    logic [RowW:0] height;
    logic [1:0]    radius;
  } geom_t;

  // Row slot of a frame row: row mod StoreRows, taken as the low bits since
  // StoreRows is a power of two.
  function automatic logic [SlotW-1:0] row_slot(input logic [RowW:0] row);
    return row[SlotW-1:0];
  endfunction
endpackage

### rtl/core/mf2d_line_store.sv
// Line store memory: one write and one registered read per cycle.
module mf2d_line_store
  import mf2d_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);
  logic [7:0] mem [StoreRows*MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### rtl/core/mf2d_select.sv
// Median search: sorted insertion over window samples, one sample per cycle.
module mf2d_select
  import mf2d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            sample_valid,
  input  logic [7:0]      sample,
  input  logic            finish,
  input  logic [CntW-1:0] rank,
  output logic [7:0]      median
);
  // Up to WinMax samples held as a sorted register row.
  logic [7:0]      regs [WinMax];
  logic [CntW-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (sample_valid) begin
      fill <= fill + 1'b1;
    end
  end

  // Insertion into a sorted row: each slot decides independently.
  always_ff @(posedge clk) begin
    if (sample_valid) begin
      for (int k = 0; k < WinMax; k++) begin
        if (k < int'(fill)) begin
          if (regs[k] > sample) begin
            if (k + 1 < WinMax) regs[k+1] <= regs[k];
          end
        end
        if (k == int'(fill) || (k < int'(fill) && regs[k] > sample)) begin
          if (k == 0 || !(k - 1 < int'(fill) && regs[k-1 > 0 ? k-1 : 0] > sample)) begin
            regs[k] <= sample;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      median <= regs[rank[$clog2(WinMax)-1:0]];
    end
  end
endmodule

### rtl/core/median_filter_2d_top.sv
// Top level of the 2D median filter with border replication.
// Channel | dir | handshake    | payload
// in      | in  | valid/stall  | cmd, pixel_in
// out     | out | valid/stall  | pixel_out, frame_end
// cfg     | in  | valid/ready  | cfg_index, cfg_data
// A request that produces a result raises out_valid after it is accepted, once
// the single line store read port has fetched every window sample, one sample
// per cycle, and the median is selected; with no output stall the next request is
// taken once out_valid drops. A request with no result leaves the input free.
// Synchronous reset clears positions and loads 640 x 480, radius 1.
// A held result blocks further input until it is taken.
module median_filter_2d_top
  import mf2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DONE} state_t;
  state_t state;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [1:0]  window_radius;
  logic [ColW:0] in_column, out_column;
  logic [RowW:0] in_row, out_row;

  logic [ColW:0] w;
  logic [RowW:0] h;
  logic [2:0]    r;
  always_comb begin
    w = (frame_width == 0) ? (ColW+1)'(1) :
        (frame_width > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(frame_width);
    h = (frame_height == 0) ? (RowW+1)'(1) :
        (frame_height > 13'(HeightLim)) ? (RowW+1)'(HeightLim) : (RowW+1)'(frame_height);
    r = (window_radius == 0) ? 3'd1 :
        (window_radius > 2'(MaxRadius)) ? 3'(MaxRadius) : {1'b0, window_radius};
  end

  logic fin_d;
  assign cfg_ready = (state == S_IDLE) && !out_valid && !fin_d;
  assign in_stall  = (state != S_IDLE) || out_valid || fin_d;
  wire in_acc  = in_valid && !in_stall;
  wire cfg_acc = cfg_valid && cfg_ready;

  // Readiness after this item's pixel is stored.
  logic [ColW:0] ic_n;
  logic [RowW:0] ir_n;
  logic          wr;
  logic [RowW:0] ty;
  logic [ColW:0] tx;
  logic          ready_n;
  always_comb begin
    wr = in_acc && (cmd == CmdPixel) && (in_row < h);
    ic_n = in_column; ir_n = in_row;
    if (wr) begin
      if (in_column + 1'b1 >= w) begin
        ic_n = '0; ir_n = in_row + 1'b1;
      end else begin
        ic_n = in_column + 1'b1;
      end
    end
    ty = ((RowW+1)'(out_row) + (RowW+1)'(r) > h - 1'b1) ? h - 1'b1 : out_row + (RowW+1)'(r);
    tx = (out_column + (ColW+1)'(r) > w - 1'b1) ? w - 1'b1 : out_column + (ColW+1)'(r);
    ready_n = (out_row < h) && (ir_n > ty || (ir_n == ty && ic_n > tx));
  end

  // Window walk counters, offsets from -r..r.
  logic signed [3:0] dy, dx;
  logic [CntW-1:0]   nsamp;
  logic              rd_pend, rd_pend2;
  logic [AddrW-1:0]  rd_addr;
  logic signed [RowW+1:0] yy;
  logic signed [ColW+1:0] xx;
  logic [RowW:0] yc;
  logic [ColW:0] xc;
  always_comb begin
    yy = $signed({1'b0, out_row}) + (RowW+2)'(dy);
    xx = $signed({1'b0, out_column}) + (ColW+2)'(dx);
    if (yy < 0) yc = '0;
    else if (yy > $signed({1'b0, h}) - 1) yc = h - 1'b1;
    else yc = yy[RowW:0];
    if (xx < 0) xc = '0;
    else if (xx > $signed({1'b0, w}) - 1) xc = w - 1'b1;
    else xc = xx[ColW:0];
    rd_addr = {row_slot(yc), xc[ColW-1:0]};
  end

  logic [7:0] rd_data;
  mf2d_line_store u_store (
    .clk(clk), .wr_en(wr),
    .wr_addr({row_slot(in_row), in_column[ColW-1:0]}),
    .wr_data(pixel_in), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  wire [CntW-1:0] total = CntW'((2*r+1)*(2*r+1));
  logic [7:0] median;
  logic       last_hold;
  // Read data lines up with the request in the cycle after the address.
  mf2d_select u_sel (
    .clk(clk), .rst(rst), .clear(state == S_IDLE),
    .sample_valid(rd_pend), .sample(rd_data),
    .finish(state == S_DONE), .rank(total >> 1), .median(median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_width <= 11'd640; frame_height <= 13'd480; window_radius <= 2'd1;
      in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
      out_valid <= 1'b0; rd_pend <= 1'b0; rd_pend2 <= 1'b0; fin_d <= 1'b0;
      dy <= '0; dx <= '0; nsamp <= '0; frame_end <= 1'b0;
    end else begin
      rd_pend2 <= rd_pend;
      rd_pend  <= 1'b0;
      fin_d    <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_acc) begin
        case (cfg_index)
          RegWidth:  frame_width <= cfg_data[10:0];
          RegHeight: frame_height <= cfg_data;
          RegRadius: window_radius <= cfg_data[1:0];
          default: ;
        endcase
        if (cfg_index == RegWidth || cfg_index == RegHeight || cfg_index == RegRadius) begin
          in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            in_column <= ic_n; in_row <= ir_n;
            if (ready_n) begin
              state <= S_FETCH;
              dy <= -$signed({1'b0, r}); dx <= -$signed({1'b0, r});
              nsamp <= '0;
            end
          end
        end
        S_FETCH: begin
          if (nsamp < total) begin
            rd_pend <= 1'b1;
            nsamp <= nsamp + 1'b1;
            if (dx == $signed({1'b0, r})) begin
              dx <= -$signed({1'b0, r}); dy <= dy + 4'sd1;
            end else begin
              dx <= dx + 4'sd1;
            end
          end else if (!rd_pend && !rd_pend2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          fin_d <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (fin_d) begin
        out_valid <= 1'b1;
        frame_end <= last_hold;
        if (last_hold) begin
          in_column <= '0; in_row <= '0; out_column <= '0; out_row <= '0;
        end else if (out_column + 1'b1 >= w) begin
          out_column <= '0; out_row <= out_row + 1'b1;
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
    end
  end

  assign last_hold = (out_row == h - 1'b1) && (out_column == w - 1'b1);
  assign pixel_out = median;

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    fin_d |=> out_valid) else $error("result lost");
  a_in_bound: assert property (@(posedge clk) disable iff (rst)
    in_column < (ColW+1)'(MaxWidth)) else $error("column overflow");
`endif
endmodule
